FILE: sv/rgb_led_matrix_glyph_and_scan_defines.svh
// ----------------------------------------------------------------------------
// LED matrix driver assertion macros
// Shared assertion helpers for the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_MATRIX_GLYPH_AND_SCAN_DEFINES_SVH
`define RGB_LED_MATRIX_GLYPH_AND_SCAN_DEFINES_SVH

// implication checked on every clock outside reset
`define LMX_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define LMX_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/lmx_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix driver package
// Item types, command codes and the glyph font table.
// ----------------------------------------------------------------------------
package lmx_pkg;

	localparam int GRID_ROWS = 8;
	localparam int ROW_W     = $clog2(GRID_ROWS);
	localparam int GLYPH_ROWS = 6;
	localparam int SCAN_BITS = 32;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_GLYPH = 2'd1,
		CMD_ROW   = 2'd2,
		CMD_SCAN  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_WIDTH = 2'd1,
		KIND_BIT   = 2'd2
	} kind_t;

	localparam logic [1:0] PLANE_R = 2'd0;
	localparam logic [1:0] PLANE_G = 2'd1;
	localparam logic [1:0] PLANE_B = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [1:0]        plane;
		logic [7:0]        char_code;
		logic signed [7:0] x_offset;
		logic signed [3:0] y_offset;
		logic [2:0]        row_select;
		logic [7:0]        row_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] glyph_width;
		logic       serial_bit;
		logic [2:0] scan_row;
		logic [1:0] scan_colour;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [2:0] width;
		logic [4:0] r0, r1, r2, r3, r4, r5;
	} glyph_t;

	// datapath commands
	typedef struct packed {
		logic            load;   // capture input item
		logic            clear;
		logic            row_wr;
		logic            advance; // scan phase/row step
		logic            draw;   // draw one glyph row
		logic [2:0]      gy;     // glyph row index
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] width;
	} dp_sts_t;

	function automatic glyph_t g(input logic [2:0] w, input logic [4:0] a, b, c, d, e, f);
		glyph_t t;
		t.width = w; t.r0 = a; t.r1 = b; t.r2 = c; t.r3 = d; t.r4 = e; t.r5 = f;
		return t;
	endfunction

	function automatic glyph_t font_lookup(input logic [7:0] code);
		glyph_t t;
		case (code)
			8'h41: t = g(5, 'h6, 'h6, 'h9, 'hF, 'h9, 0);
			8'h42: t = g(5, 'h7, 'h9, 'h7, 'h9, 'h7, 0);
			8'h43: t = g(5, 'h6, 'h9, 'h1, 'h9, 'h6, 0);
			8'h44: t = g(5, 'h7, 'h9, 'h9, 'h9, 'h7, 0);
			8'h45: t = g(4, 'h7, 'h1, 'h3, 'h1, 'h7, 0);
			8'h46: t = g(4, 'h7, 'h1, 'h3, 'h1, 'h1, 0);
			8'h47: t = g(5, 'hE, 'h1, 'hD, 'h9, 'hE, 0);
			8'h48: t = g(5, 'h9, 'h9, 'hF, 'h9, 'h9, 0);
			8'h49: t = g(2, 'h1, 'h1, 'h1, 'h1, 'h1, 0);
			8'h4A: t = g(4, 'h4, 'h4, 'h4, 'h5, 'h3, 0);
			8'h4B: t = g(5, 'h9, 'h5, 'h3, 'h5, 'h9, 0);
			8'h4C: t = g(4, 'h1, 'h1, 'h1, 'h1, 'h7, 0);
			8'h4D: t = g(6, 'h11, 'h1B, 'h15, 'h11, 'h11, 0);
			8'h4E: t = g(5, 'h9, 'hB, 'hD, 'h9, 'h9, 0);
			8'h4F: t = g(5, 'h6, 'h9, 'h9, 'h9, 'h6, 0);
			8'h50: t = g(5, 'h7, 'h9, 'h7, 'h1, 'h1, 0);
			8'h51: t = g(5, 'h6, 'h9, 'h9, 'h5, 'hA, 0);
			8'h52: t = g(5, 'h7, 'h9, 'h7, 'h9, 'h9, 0);
			8'h53: t = g(5, 'hE, 'h1, 'h6, 'h8, 'h7, 0);
			8'h54: t = g(4, 'h7, 'h2, 'h2, 'h2, 'h2, 0);
			8'h55: t = g(5, 'h9, 'h9, 'h9, 'h9, 'h6, 0);
			8'h56: t = g(4, 'h5, 'h5, 'h5, 'h2, 'h2, 0);
			8'h57: t = g(6, 'h11, 'h15, 'h15, 'hA, 'hA, 0);
			8'h58: t = g(4, 'h5, 'h5, 'h2, 'h5, 'h5, 0);
			8'h59: t = g(4, 'h5, 'h5, 'h2, 'h2, 'h2, 0);
			8'h5A: t = g(4, 'h7, 'h4, 'h2, 'h1, 'h7, 0);
			8'h61: t = g(4, 0, 0, 'h6, 'h5, 'h6, 0);
			8'h62: t = g(4, 'h1, 'h1, 'h3, 'h5, 'h3, 0);
			8'h63: t = g(4, 0, 0, 'h6, 'h1, 'h6, 0);
			8'h64: t = g(4, 'h4, 'h4, 'h6, 'h5, 'h6, 0);
			8'h65: t = g(4, 0, 0, 'h2, 'h5, 'h3, 0);
			8'h66: t = g(3, 'h2, 'h1, 'h3, 'h1, 'h1, 0);
			8'h67: t = g(4, 0, 0, 'h6, 'h5, 'h6, 'h4);
			8'h68: t = g(4, 'h1, 'h1, 'h3, 'h5, 'h5, 0);
			8'h69: t = g(2, 'h1, 0, 'h1, 'h1, 'h1, 0);
			8'h6A: t = g(2, 'h1, 0, 'h1, 'h1, 'h1, 'h1);
			8'h6B: t = g(4, 'h1, 'h1, 'h5, 'h3, 'h5, 0);
			8'h6C: t = g(2, 'h1, 'h1, 'h1, 'h1, 'h1, 0);
			8'h6D: t = g(6, 0, 0, 'hF, 'h15, 'h15, 0);
			8'h6E: t = g(4, 0, 0, 'h3, 'h5, 'h5, 0);
			8'h6F: t = g(4, 0, 0, 'h7, 'h5, 'h7, 0);
			8'h70: t = g(4, 0, 0, 'h3, 'h5, 'h3, 'h1);
			8'h71: t = g(4, 0, 0, 'h6, 'h5, 'h6, 'h4);
			8'h72: t = g(3, 0, 0, 'h3, 'h1, 'h1, 0);
			8'h73: t = g(3, 0, 0, 'h3, 'h1, 'h1, 0);
			8'h74: t = g(3, 0, 'h1, 'h3, 'h1, 'h2, 0);
			8'h75: t = g(4, 0, 0, 'h5, 'h5, 'h6, 0);
			8'h76: t = g(4, 0, 0, 'h5, 'h5, 'h2, 0);
			8'h77: t = g(5, 0, 0, 'h9, 'h9, 'hF, 0);
			8'h78: t = g(4, 0, 0, 'h5, 'h2, 'h5, 0);
			8'h79: t = g(4, 0, 0, 'h5, 'h2, 'h2, 'h1);
			8'h7A: t = g(4, 0, 0, 'h7, 'h2, 'h7, 0);
			8'h20: t = g(2, 0, 0, 0, 0, 0, 0);
			8'h30: t = g(4, 'h2, 'h5, 'h5, 'h5, 'h2, 0);
			8'h31: t = g(3, 'h2, 'h3, 'h2, 'h2, 'h2, 0);
			8'h32: t = g(4, 'h3, 'h4, 'h2, 'h1, 'h7, 0);
			8'h33: t = g(4, 'h3, 'h4, 'h2, 'h4, 'h3, 0);
			8'h34: t = g(4, 'h4, 'h6, 'h5, 'h7, 'h4, 0);
			8'h35: t = g(4, 'h7, 'h1, 'h7, 'h4, 'h3, 0);
			8'h36: t = g(4, 'h2, 'h1, 'h3, 'h5, 'h2, 0);
			8'h37: t = g(4, 'h7, 'h4, 'h2, 'h2, 'h2, 0);
			8'h38: t = g(4, 'h2, 'h5, 'h2, 'h5, 'h2, 0);
			8'h39: t = g(4, 'h2, 'h5, 'h7, 'h4, 'h2, 0);
			8'h2D: t = g(3, 0, 0, 'h3, 0, 0, 0);
			8'h2B: t = g(4, 0, 'h2, 'h7, 'h2, 0, 0);
			8'h5F: t = g(4, 0, 0, 0, 0, 0, 'h7);
			8'h3D: t = g(3, 0, 0, 0, 'h3, 0, 0);
			8'h21: t = g(2, 'h1, 'h1, 'h1, 0, 'h1, 0);
			8'h3F: t = g(3, 'h1, 'h2, 'h1, 0, 'h1, 0);
			8'h2F: t = g(3, 'h2, 'h2, 'h3, 'h1, 'h1, 0);
			8'h5C: t = g(3, 'h1, 'h1, 'h3, 'h2, 'h2, 0);
			8'h7C: t = g(2, 'h1, 'h1, 'h1, 'h1, 'h1, 0);
			8'h3C: t = g(3, 0, 0, 'h2, 'h1, 'h2, 0);
			8'h3E: t = g(3, 0, 0, 'h1, 'h2, 'h1, 0);
			8'h5B: t = g(3, 'h3, 'h1, 'h1, 'h1, 'h1, 'h3);
			8'h5D: t = g(3, 'h3, 'h2, 'h2, 'h2, 'h2, 'h3);
			8'h28: t = g(3, 'h2, 'h1, 'h1, 'h1, 'h1, 'h2);
			8'h29: t = g(3, 'h1, 'h2, 'h2, 'h2, 'h2, 'h1);
			default: t = g(4, 'hF, 'hF, 'hF, 'hF, 'hF, 'hF);
		endcase
		return t;
	endfunction

endpackage

FILE: sv/lmx_datapath.sv
// ----------------------------------------------------------------------------
// LED matrix datapath
// Frame planes, glyph row drawing, scan counters and the scan bit selector.
// ----------------------------------------------------------------------------
`include "rgb_led_matrix_glyph_and_scan_defines.svh"
module lmx_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  lmx_pkg::in_item_t   item,
	input  lmx_pkg::dp_cmd_t    cmd,
	input  logic [4:0]          bit_idx,
	output lmx_pkg::dp_sts_t    sts,
	output logic                scan_bit,
	output logic [2:0]          scan_row,
	output logic [1:0]          scan_colour
);
	import lmx_pkg::*;

	in_item_t     item_q;
	glyph_t       glyph_q;
	logic [7:0]   planes_q [3][GRID_ROWS];
	logic [ROW_W-1:0] row_q;
	logic [1:0]   phase_q;

	logic [4:0]        grow;
	logic signed [4:0] rsum;
	logic [7:0]        rowbits;
	logic signed [9:0] cpos;
	logic              bit_v;

	glyph_t gl;
	assign gl = font_lookup(item.char_code);

	always_comb begin
		case (cmd.gy)
			3'd0: grow = glyph_q.r0;
			3'd1: grow = glyph_q.r1;
			3'd2: grow = glyph_q.r2;
			3'd3: grow = glyph_q.r3;
			3'd4: grow = glyph_q.r4;
			default: grow = glyph_q.r5;
		endcase
		rsum = 5'(signed'({1'b0, cmd.gy})) + 5'(item_q.y_offset);
		rowbits = '0;
		for (int x = 0; x < 6; x++) begin
			cpos = 10'(x) + 10'(item_q.x_offset);
			if (grow[x] && cpos >= 0 && cpos < 8)
				rowbits[cpos[2:0]] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= item;
			glyph_q <= gl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			phase_q <= '0;
			for (int p = 0; p < 3; p++)
				for (int r = 0; r < GRID_ROWS; r++)
					planes_q[p][r] <= '0;
		end else begin
			if (cmd.clear) begin
				for (int p = 0; p < 3; p++)
					for (int r = 0; r < GRID_ROWS; r++)
						planes_q[p][r] <= '0;
			end
			if (cmd.row_wr && item_q.plane != 2'd3)
				planes_q[item_q.plane][item_q.row_select] <= item_q.row_value;
			if (cmd.draw && item_q.plane != 2'd3 && rsum >= 0 && rsum < 5'(GRID_ROWS))
				planes_q[item_q.plane][rsum[2:0]] <=
					planes_q[item_q.plane][rsum[2:0]] | rowbits;
			if (cmd.advance) begin
				if (phase_q == PLANE_B) begin
					phase_q <= PLANE_R;
					row_q   <= row_q + 1'b1;
				end else begin
					phase_q <= phase_q + 2'd1;
				end
			end
		end
	end

	// scan bit selection; groups of four
	always_comb begin
		logic [1:0] grp;
		logic [2:0] col;
		logic [1:0] pl;
		grp   = bit_idx[4:3];
		col   = bit_idx[2] ? (3'd7 - {1'b0, bit_idx[1:0]}) : (3'd3 - {1'b0, bit_idx[1:0]});
		pl    = PLANE_G;
		bit_v = 1'b1;
		case (grp)
			2'd0: pl = PLANE_G;
			2'd1: pl = PLANE_G;
			2'd2: pl = PLANE_B;
			default: pl = PLANE_R;
		endcase
		if (grp == 2'd0 && !bit_idx[2])
			bit_v = (row_q == {1'b1, bit_idx[1:0]});
		else if (grp == 2'd1 && !bit_idx[2])
			bit_v = (row_q == {1'b0, bit_idx[1:0]});
		else begin
			if (grp[1]) col = bit_idx[2] ? (3'd7 - {1'b0, bit_idx[1:0]})
			                             : (3'd3 - {1'b0, bit_idx[1:0]});
			else col = 3'd3 - {1'b0, bit_idx[1:0]} + (grp == 2'd1 ? 3'd4 : 3'd0);
			bit_v = !(planes_q[pl][row_q][col] && phase_q == pl);
		end
	end

	assign scan_bit    = bit_v;
	assign scan_row    = row_q;
	assign scan_colour = phase_q;
	assign sts.width   = glyph_q.width;

	`LMX_ASSERT_IMP(a_phase_range, 1'b1, phase_q != 2'd3)
	`LMX_ASSERT_NXT(a_adv_wrap, cmd.advance && phase_q == PLANE_B, phase_q == PLANE_R)
	`LMX_ASSERT_NXT(a_row_step, cmd.advance && phase_q == PLANE_B,
		row_q == $past(row_q) + 3'd1)

endmodule

FILE: sv/lmx_ctrl.sv
// ----------------------------------------------------------------------------
// LED matrix controller
// Sequences each item and drives the registered result.
// ----------------------------------------------------------------------------
`include "rgb_led_matrix_glyph_and_scan_defines.svh"
module lmx_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_cmd,
	output logic               in_stall,
	output lmx_pkg::dp_cmd_t   cmd,
	output logic [4:0]         bit_idx,
	input  lmx_pkg::dp_sts_t   sts,
	input  logic               scan_bit,
	input  logic [2:0]         scan_row,
	input  logic [1:0]         scan_colour,
	output logic               out_valid,
	input  logic               out_stall,
	output lmx_pkg::out_item_t out_item
);
	import lmx_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_DECODE, ST_DRAW, ST_SCAN, ST_REPLY} state_t;

	state_t     state_q;
	logic [1:0] cmd_q;
	logic [2:0] gy_q;
	logic [4:0] idx_q;
	logic       ovalid_q;
	out_item_t  oitem_q;
	logic       free;
	logic       acc;
	logic       emit;

	assign free     = !ovalid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign emit     = free && (state_q == ST_SCAN || state_q == ST_REPLY);

	always_comb begin
		cmd         = '0;
		cmd.load    = acc;
		cmd.gy      = gy_q;
		cmd.clear   = (state_q == ST_DECODE) && cmd_q == CMD_CLEAR;
		cmd.row_wr  = (state_q == ST_DECODE) && cmd_q == CMD_ROW;
		cmd.advance = (state_q == ST_DECODE) && cmd_q == CMD_SCAN;
		cmd.draw    = (state_q == ST_DRAW);
	end
	assign bit_idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cmd_q    <= CMD_CLEAR;
			gy_q     <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
			oitem_q  <= '0;
		end else begin
			if (emit) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cmd_q <= in_cmd;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					gy_q  <= '0;
					idx_q <= '0;
					case (cmd_q)
						CMD_GLYPH: state_q <= ST_DRAW;
						CMD_SCAN:  state_q <= ST_SCAN;
						default:   state_q <= ST_REPLY;
					endcase
				end
				ST_DRAW: begin
					gy_q <= gy_q + 3'd1;
					if (gy_q == 3'(GLYPH_ROWS - 1)) state_q <= ST_REPLY;
				end
				ST_SCAN: begin
					if (free) begin
						oitem_q  <= '{kind: KIND_BIT, glyph_width: 3'd0, serial_bit: scan_bit,
							scan_row: scan_row, scan_colour: scan_colour,
							last: (idx_q == 5'(SCAN_BITS - 1))};
						idx_q <= idx_q + 5'd1;
						if (idx_q == 5'(SCAN_BITS - 1)) state_q <= ST_IDLE;
					end
				end
				ST_REPLY: begin
					if (free) begin
						oitem_q  <= '{kind: (cmd_q == CMD_GLYPH) ? KIND_WIDTH : KIND_ACK,
							glyph_width: (cmd_q == CMD_GLYPH) ? sts.width : 3'd0,
							serial_bit: 1'b0, scan_row: 3'd0, scan_colour: 2'd0, last: 1'b1};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign out_item  = oitem_q;

	`LMX_ASSERT_NXT(a_out_hold, ovalid_q && out_stall, ovalid_q && $stable(oitem_q))
	`LMX_ASSERT_IMP(a_busy_stall, state_q != ST_IDLE, in_stall)
	`LMX_ASSERT_NXT(a_scan_last, state_q == ST_SCAN && free && idx_q == 5'd31,
		oitem_q.last && state_q == ST_IDLE)

endmodule

FILE: sv/rgb_led_matrix_glyph_and_scan.sv
// ----------------------------------------------------------------------------
// RGB LED matrix glyph and scan driver
// 8x8 three-plane frame with glyph drawing and serial scan output.
// ----------------------------------------------------------------------------
// channel | dir | handshake         | payload
// in      | in  | in_valid/in_stall | in_item_t
// out     | out | out_valid/out_stall | out_item_t
//
// Clear and row write: applied in the decode state; the acknowledge is registered in the reply state.
// Glyph: one glyph row drawn per cycle through the frame write port, then the width reply.
// Scan tick: after decode, one serial bit per cycle while the output is not stalled, 32 bits.
// Reset clears frame and scan counters at once; output stalls hold the scan and reply states.
// ----------------------------------------------------------------------------
module rgb_led_matrix_glyph_and_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lmx_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output lmx_pkg::out_item_t out_item
);
	import lmx_pkg::*;

	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic [4:0] bit_idx;
	logic       scan_bit;
	logic [2:0] scan_row;
	logic [1:0] scan_colour;

	lmx_datapath u_dp (
		.clk, .arst_n, .item(in_item), .cmd, .bit_idx, .sts,
		.scan_bit, .scan_row, .scan_colour
	);

	lmx_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_cmd(in_item.command), .in_stall,
		.cmd, .bit_idx, .sts, .scan_bit, .scan_row, .scan_colour,
		.out_valid, .out_stall, .out_item
	);

endmodule
